/* sv/crorm_pkg.sv */
// ----------------------------------------------------------------------------
// crorm_pkg
// Shared constants, codes and types of the cascaded range offset remap core.
// ----------------------------------------------------------------------------
package crorm_pkg;

  // Table geometry
  localparam int unsigned STAGE_COUNT       = 8;
  localparam int unsigned ENTRIES_PER_STAGE = 32;
  localparam int unsigned TABLE_DEPTH       = STAGE_COUNT * ENTRIES_PER_STAGE;
  localparam int unsigned ADDR_W            = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W             = $clog2(ENTRIES_PER_STAGE + 1);

  // Field widths fixed by the transaction format
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAGE_W = 3;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned ENTRY_W = 3 * VALUE_W;

  // Value range actually used
  localparam int unsigned VALUE_BITS = 32;
  localparam logic [VALUE_W-1:0] VALUE_MASK =
    (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

  // Configuration register map
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_STAGES_IN_USE = 1'b0;  // word index of register 0
  localparam logic [CFG_W-1:0] STAGES_RESET  = CFG_W'(7);
  localparam logic [CFG_W-1:0] STAGES_MAX    = CFG_W'(STAGE_COUNT);

  // Command codes (code 3 is unused)
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } crorm_cmd_e;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_STAGE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } crorm_status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_QSTAGE,
    S_QSCAN,
    S_QAPPLY,
    S_EMIT
  } crorm_state_e;

  // Input transaction payload
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [STAGE_W-1:0] stage_index;
    logic [VALUE_W-1:0] dst_base;
    logic [VALUE_W-1:0] src_base;
    logic [VALUE_W-1:0] span_length;
    logic [VALUE_W-1:0] query_value;
  } crorm_req_t;

  // Result transaction payload
  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [VALUE_W-1:0] mapped_value;
    logic [VALUE_W-1:0] lowest_so_far;
  } crorm_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture input transaction
    logic exec;        // run clear / append / unused command
    logic stage_next;  // advance walk to next stage
    logic scan_start;  // read first entry of current stage
    logic scan_step;   // compare one entry, read the next
    logic apply;       // apply best entry of the stage
    logic q_finish;    // finish query, update minimum
    logic emit;        // move result into output register
  } crorm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             stage_done;
    logic             stage_empty;
    logic             scan_last;
    logic             out_free;
  } crorm_sts_t;

  // Table address of an entry within a stage
  function automatic logic [ADDR_W-1:0] table_addr(logic [STAGE_W-1:0] stage,
                                                   logic [CNT_W-1:0]   entry);
    return ADDR_W'(int'(stage) * ENTRIES_PER_STAGE + int'(entry));
  endfunction

endpackage

/* sv/crorm_req_if.sv */
// ----------------------------------------------------------------------------
// crorm_req_if
// Input channel: valid/ready handshake with command payload.
// ----------------------------------------------------------------------------
interface crorm_req_if;
  import crorm_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [STAGE_W-1:0] stage_index;
  logic [VALUE_W-1:0] dst_base;
  logic [VALUE_W-1:0] src_base;
  logic [VALUE_W-1:0] span_length;
  logic [VALUE_W-1:0] query_value;

  modport source (
    output valid, command, stage_index, dst_base, src_base, span_length, query_value,
    input  ready
  );

  modport sink (
    input  valid, command, stage_index, dst_base, src_base, span_length, query_value,
    output ready
  );
endinterface

/* sv/crorm_rsp_if.sv */
// ----------------------------------------------------------------------------
// crorm_rsp_if
// Result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface crorm_rsp_if;
  import crorm_pkg::*;

  logic               valid;
  logic               ready;
  logic [STS_W-1:0]   status;
  logic [VALUE_W-1:0] mapped_value;
  logic [VALUE_W-1:0] lowest_so_far;

  modport source (
    output valid, status, mapped_value, lowest_so_far,
    input  ready
  );

  modport sink (
    input  valid, status, mapped_value, lowest_so_far,
    output ready
  );
endinterface

/* sv/crorm_ram.sv */
// ----------------------------------------------------------------------------
// crorm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crorm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/crorm_ctrl.sv */
// ----------------------------------------------------------------------------
// crorm_ctrl
// Sequencer: accepts a transaction, runs the command and walks the stages.
// ----------------------------------------------------------------------------
module crorm_ctrl import crorm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_command_i,
  output logic             in_ready_o,
  input  crorm_sts_t       sts_i,
  output crorm_cmd_t       cmd_o
);

  crorm_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_command_i == CMD_QUERY) ? S_QSTAGE : S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_EMIT;
      end
      S_QSTAGE: begin
        if (sts_i.stage_done) begin
          state_d = S_EMIT;
        end else if (!sts_i.stage_empty) begin
          state_d = S_QSCAN;
        end
      end
      S_QSCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_QAPPLY;
        end
      end
      S_QAPPLY: begin
        state_d = S_QSTAGE;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_QSTAGE: begin
        if (sts_i.stage_done) begin
          cmd_o.q_finish = 1'b1;
        end else if (sts_i.stage_empty) begin
          cmd_o.stage_next = 1'b1;
        end else begin
          cmd_o.scan_start = 1'b1;
        end
      end
      S_QSCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      S_QAPPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.stage_next = 1'b1;
      end
      S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* sv/crorm_dp.sv */
// ----------------------------------------------------------------------------
// crorm_dp
// Datapath: entry table, per-stage counts, stage walk, minimum and result.
// ----------------------------------------------------------------------------
module crorm_dp import crorm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crorm_cmd_t       cmd_i,
  output crorm_sts_t       sts_o,
  input  crorm_req_t       req_i,
  input  logic [CFG_W-1:0] act_stages_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output crorm_rsp_t       rsp_o
);

  // Captured transaction
  logic [CMD_W-1:0]   command_q;
  logic [STAGE_W-1:0] stage_q;
  logic [VALUE_W-1:0] dest_q, src_q, len_q;

  // Walk state
  logic [VALUE_W-1:0] v_q;
  logic [CFG_W-1:0]   walk_q;
  logic [CNT_W-1:0]   entry_q;
  logic               found_q;
  logic [VALUE_W-1:0] best_src_q, best_dest_q, best_off_q;

  // Table bookkeeping and results
  logic [CNT_W-1:0]   count_q [STAGE_COUNT];
  logic [VALUE_W-1:0] min_q;
  logic [STS_W-1:0]   res_status_q;
  logic [VALUE_W-1:0] res_mapped_q;
  logic               out_valid_q;
  crorm_rsp_t         out_q;

  // Table access
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [VALUE_W-1:0] e_dest, e_src, e_len;

  // Entry checks
  logic [STAGE_W-1:0] walk_idx;
  logic [CNT_W-1:0]   walk_cnt, entry_nx;
  logic [VALUE_W:0]   diff;
  logic               hit, better;
  logic [VALUE_W-1:0] lim;
  logic               ovf, is_clear;
  logic [STS_W-1:0]   exec_status;

  assign walk_idx = walk_q[STAGE_W-1:0];
  assign walk_cnt = count_q[walk_idx];
  assign entry_nx = entry_q + CNT_W'(1);

  // Status to the controller
  always_comb begin
    sts_o.command     = command_q;
    sts_o.stage_done  = (walk_q >= act_stages_i);
    sts_o.stage_empty = (walk_cnt == '0);
    sts_o.scan_last   = (entry_nx == walk_cnt);
    sts_o.out_free    = !out_valid_q || rsp_ready_i;
  end

  // Append checks: stage range, end overflow, stage full
  assign lim      = VALUE_MASK - (len_q - VALUE_W'(1));
  assign ovf      = (len_q != '0) && ((src_q > lim) || (dest_q > lim));
  assign is_clear = cmd_i.exec && (command_q == CMD_CLEAR);

  always_comb begin
    exec_status = ST_OK;
    wr_en       = 1'b0;
    if (cmd_i.exec && (command_q == CMD_APPEND)) begin
      if (CFG_W'(stage_q) >= act_stages_i) begin
        exec_status = ST_BAD_STAGE;
      end else if (ovf) begin
        exec_status = ST_OVERFLOW;
      end else if (count_q[stage_q] >= CNT_W'(ENTRIES_PER_STAGE)) begin
        exec_status = ST_FULL;
      end else begin
        wr_en = 1'b1;
      end
    end
  end

  assign wr_addr = table_addr(stage_q, count_q[stage_q]);
  assign rd_en   = cmd_i.scan_start || cmd_i.scan_step;
  assign rd_addr = cmd_i.scan_start ? table_addr(walk_idx, '0) : table_addr(walk_idx, entry_nx);

  crorm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i ({dest_q, src_q, len_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Containment test of the entry just read
  assign e_dest = rd_data[3*VALUE_W-1:2*VALUE_W];
  assign e_src  = rd_data[2*VALUE_W-1:VALUE_W];
  assign e_len  = rd_data[VALUE_W-1:0];
  assign diff   = {1'b0, v_q} - {1'b0, e_src};
  assign hit    = (e_len != '0) && !diff[VALUE_W] &&
                  (diff[VALUE_W-1:0] <= (e_len - VALUE_W'(1)));
  assign better = !found_q || (e_src < best_src_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGE_COUNT; s++) begin
        count_q[s] <= '0;
      end
      min_q       <= VALUE_MASK;
      out_valid_q <= 1'b0;
      walk_q      <= '0;
      entry_q     <= '0;
      found_q     <= 1'b0;
    end else begin
      if (is_clear) begin
        for (int s = 0; s < STAGE_COUNT; s++) begin
          count_q[s] <= '0;
        end
        min_q <= VALUE_MASK;
      end
      if (wr_en) begin
        count_q[stage_q] <= count_q[stage_q] + CNT_W'(1);
      end
      if (cmd_i.q_finish && (v_q < min_q)) begin
        min_q <= v_q;
      end
      if (cmd_i.load) begin
        walk_q <= '0;
      end else if (cmd_i.stage_next) begin
        walk_q <= walk_q + CFG_W'(1);
      end
      if (cmd_i.scan_start) begin
        entry_q <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        entry_q <= entry_nx;
        if (hit && better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      command_q <= req_i.command;
      stage_q   <= req_i.stage_index;
      dest_q    <= req_i.dst_base & VALUE_MASK;
      src_q     <= req_i.src_base & VALUE_MASK;
      len_q     <= req_i.span_length & VALUE_MASK;
      v_q       <= req_i.query_value & VALUE_MASK;
    end else if (cmd_i.apply && found_q) begin
      v_q <= (best_dest_q + best_off_q) & VALUE_MASK;
    end
    if (cmd_i.scan_step && hit && better) begin
      best_src_q  <= e_src;
      best_dest_q <= e_dest;
      best_off_q  <= diff[VALUE_W-1:0];
    end
    if (cmd_i.exec) begin
      res_status_q <= exec_status;
      res_mapped_q <= '0;
    end else if (cmd_i.q_finish) begin
      res_status_q <= ST_OK;
      res_mapped_q <= v_q;
    end
    if (cmd_i.emit) begin
      out_q.status        <= res_status_q;
      out_q.mapped_value  <= res_mapped_q;
      out_q.lowest_so_far <= min_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

`ifndef SYNTH
  // A stored entry always lands below the stage capacity
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (count_q[stage_q] < CNT_W'(ENTRIES_PER_STAGE)))
    else $error("table write beyond stage capacity");

  // A result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || rsp_ready_i))
    else $error("result overwrote a pending transaction");

  // Clear restores the minimum and empties stage 0
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_clear |=> ((min_q == VALUE_MASK) && (count_q[0] == '0)))
    else $error("clear did not restore state");

  // Minimum only rises through a clear
  a_min_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_clear |=> (min_q <= $past(min_q)))
    else $error("running minimum increased");

  // Entries are only scanned within the stages in use
  a_scan_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_start || cmd_i.scan_step) |-> (walk_q < act_stages_i))
    else $error("scan outside active stages");
`endif

endmodule

/* sv/cascaded_range_offset_remap_core.sv */
// ----------------------------------------------------------------------------
// cascaded_range_offset_remap_core
// Multi-stage interval offset remap with per-stage entry table and minimum.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               contents
//  req_i     in         valid/ready             command, stage, entry, query
//  rsp_o     out        valid/ready             status, mapped value, minimum
//  APB       in         psel/penable, pready=1  stages_in_use at byte 0
//
//  Clear, append and unused commands pass through the execute and emit
//  states before the next acceptance. A query walks each stage in use: an
//  empty stage is skipped, otherwise the entry table RAM is read one entry
//  per cycle and the best entry found is applied to the value.
//  Reset empties all stages and sets the minimum to all ones; table
//  contents are not cleared. A stalled result holds in the output register
//  while the next transaction is accepted; its completion waits for room.
// ----------------------------------------------------------------------------
module cascaded_range_offset_remap_core import crorm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  crorm_req_if.sink           req_i,
  crorm_rsp_if.source         rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [CFG_W-1:0] stages_q;
  logic [CFG_W-1:0] act_stages;
  logic             reg_hit;
  crorm_cmd_t       cmd;
  crorm_sts_t       sts;
  crorm_req_t       req;
  crorm_rsp_t       rsp;
  logic             in_ready;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_STAGES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stages_q <= STAGES_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      stages_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata     = reg_hit ? {{(32 - CFG_W){1'b0}}, stages_q} : '0;
  assign act_stages = (stages_q > STAGES_MAX) ? STAGES_MAX : stages_q;

  // Channel payloads
  always_comb begin
    req.command     = req_i.command;
    req.stage_index = req_i.stage_index;
    req.dst_base    = req_i.dst_base;
    req.src_base    = req_i.src_base;
    req.span_length = req_i.span_length;
    req.query_value = req_i.query_value;
  end

  assign req_i.ready         = in_ready;
  assign rsp_o.status        = rsp.status;
  assign rsp_o.mapped_value  = rsp.mapped_value;
  assign rsp_o.lowest_so_far = rsp.lowest_so_far;

  crorm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (in_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  crorm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_i        (req),
    .act_stages_i (act_stages),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_o        (rsp)
  );

endmodule
